[src/lmbu_pkg.sv]
package lmbu_pkg;

  // Map and arithmetic sizing
  localparam int MAP_SIDE_MAX    = 256;
  localparam int FRAC_BITS       = 16;
  localparam int HIGH_COORD_BITS = 12;

  localparam int LABEL_W  = 8;
  localparam int SIZE_W   = 9;
  localparam int SCALE_W  = FRAC_BITS + 1;
  localparam int SIDE_BITS = $clog2(MAP_SIDE_MAX);
  localparam int HALF_W   = SIDE_BITS - 1;
  localparam int BANK_AW  = 2 * HALF_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int NUM_BANKS = 4;

  localparam int POS_W  = HIGH_COORD_BITS + SCALE_W;
  localparam int CELL_W = POS_W - FRAC_BITS;
  localparam int WT_W   = 2 * FRAC_BITS + 1;
  localparam int TERM_W = 2 * FRAC_BITS + LABEL_W;

  localparam logic [SCALE_W-1:0] ONE_FIX = SCALE_W'(1) << FRAC_BITS;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int REG_IDX_LSB = 2;
  localparam logic REG_SIZE  = 1'b0;
  localparam logic REG_SCALE = 1'b1;
  localparam logic [SIZE_W-1:0]  RST_SIZE  = SIZE_W'(256);
  localparam logic [SCALE_W-1:0] RST_SCALE = SCALE_W'(65280);

  // Opcodes and corner codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;
  localparam logic [1:0] CORNER_D = 2'd3;

  // Issue to result latency in clock edges
  localparam int PIPE_LAT = 6;

  typedef logic [LABEL_W-1:0] label_t;
  typedef logic [WT_W-1:0]    weight_t;
  typedef logic [TERM_W-1:0]  term_t;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
    label_t             data;
  } ram_wr_t;

endpackage

[src/lmbu_ram.sv]
module lmbu_ram (
  input  logic                        clk,
  input  lmbu_pkg::ram_wr_t           wr,
  input  logic [lmbu_pkg::BANK_AW-1:0] rd_addr,
  output lmbu_pkg::label_t            rd_data_r
);
  import lmbu_pkg::*;

  label_t mem [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

[src/label_map_bilinear_upsampler_top.sv]
// Label map bilinear upsampler.
//
// Holds a square map of 8-bit labels (up to 256 x 256) and answers pixel
// queries for a larger image laid over it. Input channel: a word is taken
// at each rising edge with start high and busy low. opcode 0 stores
// label_in at map column coord_x, row coord_y (ignored outside the side in
// use); opcode 1 queries image pixel (coord_x, coord_y) and yields exactly
// one result word; a write yields none. busy is high only while rst_n is
// held low, so one word per clock is accepted at all other times.
// Result channel: out_valid marks each result for one cycle; out_label_out
// is the chosen corner label and out_corner_pick the corner (A, B, C, D).
// The receiver cannot stall, so nothing ever backs up.
// Throughput is one word per clock, set by a six-register pipeline:
// coordinate multiply, cell clamp and four-bank map read with weight
// products, label-times-weight multiply, blend sum, distances, and pick.
// The map is split into four banks by row and column parity so the four
// corners are read in the same cycle through one read port per bank.
// Configuration: APB registers low_res_size at 0x0 and scale_q16 at 0x4,
// to be written by the user only while idle; the block does not enforce it.
// Reset restores 256 and 65280; map contents are undefined until written and get no clearing pass.
module label_map_bilinear_upsampler_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_opcode,
  input  logic [lmbu_pkg::HIGH_COORD_BITS-1:0] in_coord_x,
  input  logic [lmbu_pkg::HIGH_COORD_BITS-1:0] in_coord_y,
  input  logic [lmbu_pkg::LABEL_W-1:0]         in_label_in,
  output logic                                 out_valid,
  output logic [lmbu_pkg::LABEL_W-1:0]         out_label_out,
  output logic [1:0]                           out_corner_pick,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lmbu_pkg::CFG_AW-1:0]          paddr,
  input  logic [lmbu_pkg::CFG_DW-1:0]          pwdata,
  output logic [lmbu_pkg::CFG_DW-1:0]          prdata,
  output logic                                 pready
);
  import lmbu_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers. Keep the written value for readback and a
  // saturated copy that feeds the datapath.
  // ---------------------------------------------------------------------
  logic [SIZE_W-1:0]  size_r;
  logic [SIZE_W-1:0]  side_r;
  logic [SCALE_W-1:0] scale_r;
  logic [SCALE_W-1:0] scale_eff_r;
  logic               cfg_wr;
  logic [SIZE_W-1:0]  size_wr;
  logic [SIZE_W-1:0]  side_wr;
  logic [SCALE_W-1:0] scale_wr;
  logic [SCALE_W-1:0] scale_eff_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign size_wr = pwdata[SIZE_W-1:0];
  assign scale_wr = pwdata[SCALE_W-1:0];

  // A zero side acts as one cell, anything past the map acts as the full map.
  assign side_wr = (size_wr == '0) ? SIZE_W'(1) :
                   (size_wr > SIZE_W'(MAP_SIDE_MAX)) ? SIZE_W'(MAP_SIDE_MAX) : size_wr;
  // Scale above 1.0 saturates to 1.0.
  assign scale_eff_wr = (scale_wr > ONE_FIX) ? ONE_FIX : scale_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= RST_SIZE;
      side_r      <= RST_SIZE;
      scale_r     <= RST_SCALE;
      scale_eff_r <= RST_SCALE;
    end else if (cfg_wr) begin
      unique case (paddr[REG_IDX_LSB])
        REG_SIZE: begin
          size_r <= size_wr;
          side_r <= side_wr;
        end
        REG_SCALE: begin
          scale_r     <= scale_wr;
          scale_eff_r <= scale_eff_wr;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_IDX_LSB])
      REG_SIZE:  prdata = {{(CFG_DW-SIZE_W){1'b0}}, size_r};
      REG_SCALE: prdata = {{(CFG_DW-SCALE_W){1'b0}}, scale_r};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Stage 1: take the word and scale both coordinates.
  // ---------------------------------------------------------------------
  logic accept;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  logic                       s1_vld_r;
  logic                       s1_op_r;
  logic [HIGH_COORD_BITS-1:0] s1_x_r;
  logic [HIGH_COORD_BITS-1:0] s1_y_r;
  label_t                     s1_lbl_r;
  logic [POS_W-1:0]           s1_px_r;
  logic [POS_W-1:0]           s1_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r  <= in_opcode;
    s1_x_r   <= in_coord_x;
    s1_y_r   <= in_coord_y;
    s1_lbl_r <= in_label_in;
    s1_px_r  <= POS_W'(in_coord_x) * POS_W'(scale_eff_r);
    s1_py_r  <= POS_W'(in_coord_y) * POS_W'(scale_eff_r);
  end

  // ---------------------------------------------------------------------
  // Stage 2: clamp the cell, address the four banks, store writes, and
  // form the four bilinear weights.
  // ---------------------------------------------------------------------
  logic [CELL_W-1:0]    cx;
  logic [CELL_W-1:0]    cy;
  logic [CELL_W-1:0]    side_ext;
  logic [CELL_W-1:0]    xc;
  logic [CELL_W-1:0]    yc;
  logic [SIDE_BITS-1:0] x0;
  logic [SIDE_BITS-1:0] y0;
  logic [SIZE_W-1:0]    x1;
  logic [SIZE_W-1:0]    y1;
  logic                 right_ok;
  logic                 below_ok;
  logic [HALF_W-1:0]    col_e;
  logic [HALF_W-1:0]    col_o;
  logic [HALF_W-1:0]    row_e;
  logic [HALF_W-1:0]    row_o;
  logic [FRAC_BITS-1:0] fx;
  logic [FRAC_BITS-1:0] fy;
  logic [SCALE_W-1:0]   gx;
  logic [SCALE_W-1:0]   gy;
  logic                 wr_ok;

  logic [BANK_AW-1:0] bank_raddr [NUM_BANKS];
  ram_wr_t            bank_wr    [NUM_BANKS];
  label_t             bank_q     [NUM_BANKS];

  assign cx       = s1_px_r[POS_W-1:FRAC_BITS];
  assign cy       = s1_py_r[POS_W-1:FRAC_BITS];
  assign fx       = s1_px_r[FRAC_BITS-1:0];
  assign fy       = s1_py_r[FRAC_BITS-1:0];
  assign side_ext = CELL_W'(side_r);

  // A cell at or past the side clamps to the last cell.
  assign xc = (cx >= side_ext) ? side_ext - CELL_W'(1) : cx;
  assign yc = (cy >= side_ext) ? side_ext - CELL_W'(1) : cy;
  assign x0 = xc[SIDE_BITS-1:0];
  assign y0 = yc[SIDE_BITS-1:0];
  assign x1 = SIZE_W'(x0) + SIZE_W'(1);
  assign y1 = SIZE_W'(y0) + SIZE_W'(1);
  assign right_ok = x1 < side_r;
  assign below_ok = y1 < side_r;

  // Even bank takes whichever of x0 and x0+1 is even, odd bank the other.
  assign col_e = x0[0] ? x1[SIDE_BITS-1:1] : x0[SIDE_BITS-1:1];
  assign col_o = x0[0] ? x0[SIDE_BITS-1:1] : x1[SIDE_BITS-1:1];
  assign row_e = y0[0] ? y1[SIDE_BITS-1:1] : y0[SIDE_BITS-1:1];
  assign row_o = y0[0] ? y0[SIDE_BITS-1:1] : y1[SIDE_BITS-1:1];

  // Bank index is {row parity, column parity}.
  assign bank_raddr[0] = {row_e, col_e};
  assign bank_raddr[1] = {row_e, col_o};
  assign bank_raddr[2] = {row_o, col_e};
  assign bank_raddr[3] = {row_o, col_o};

  assign wr_ok = s1_vld_r && (s1_op_r == OP_WRITE) &&
                 (CELL_W'(s1_x_r) < side_ext) && (CELL_W'(s1_y_r) < side_ext);

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    assign bank_wr[b].en   = wr_ok && ({s1_y_r[0], s1_x_r[0]} == 2'(b));
    assign bank_wr[b].addr = {s1_y_r[SIDE_BITS-1:1], s1_x_r[SIDE_BITS-1:1]};
    assign bank_wr[b].data = s1_lbl_r;

    lmbu_ram u_ram (
      .clk       (clk),
      .wr        (bank_wr[b]),
      .rd_addr   (bank_raddr[b]),
      .rd_data_r (bank_q[b])
    );
  end

  assign gx = ONE_FIX - SCALE_W'(fx);
  assign gy = ONE_FIX - SCALE_W'(fy);

  logic    s2_vld_r;
  logic    s2_xp_r;
  logic    s2_yp_r;
  logic    s2_rok_r;
  logic    s2_bok_r;
  weight_t s2_w_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r && (s1_op_r == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    s2_xp_r   <= x0[0];
    s2_yp_r   <= y0[0];
    s2_rok_r  <= right_ok;
    s2_bok_r  <= below_ok;
    s2_w_r[0] <= WT_W'(gx) * WT_W'(gy);
    s2_w_r[1] <= WT_W'(fx) * WT_W'(gy);
    s2_w_r[2] <= WT_W'(gx) * WT_W'(fy);
    s2_w_r[3] <= WT_W'(fx) * WT_W'(fy);
  end

  // ---------------------------------------------------------------------
  // Stage 3: route bank data to corners, apply the edge rules, and weight
  // each corner label.
  // ---------------------------------------------------------------------
  label_t raw_a;
  label_t raw_b;
  label_t raw_c;
  label_t raw_d;
  label_t corner [4];

  assign raw_a = bank_q[{s2_yp_r, s2_xp_r}];
  assign raw_b = bank_q[{s2_yp_r, ~s2_xp_r}];
  assign raw_c = bank_q[{~s2_yp_r, s2_xp_r}];
  assign raw_d = bank_q[{~s2_yp_r, ~s2_xp_r}];

  always_comb begin
    corner[0] = raw_a;
    corner[1] = s2_rok_r ? raw_b : raw_a;
    corner[2] = s2_bok_r ? raw_c : raw_a;
    // Right edge copies C, else bottom edge copies B.
    priority if (!s2_rok_r) begin
      corner[3] = corner[2];
    end else if (!s2_bok_r) begin
      corner[3] = corner[1];
    end else begin
      corner[3] = raw_d;
    end
  end

  logic   s3_vld_r;
  label_t s3_c_r [4];
  term_t  s3_t_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      s3_c_r[k] <= corner[k];
      s3_t_r[k] <= TERM_W'(corner[k]) * TERM_W'(s2_w_r[k]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: sum the weighted terms into the exact blend.
  // ---------------------------------------------------------------------
  logic   s4_vld_r;
  label_t s4_c_r [4];
  term_t  s4_blend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_c_r     <= s3_c_r;
    s4_blend_r <= (s3_t_r[0] + s3_t_r[1]) + (s3_t_r[2] + s3_t_r[3]);
  end

  // ---------------------------------------------------------------------
  // Stage 5: distance of each corner label from the blend, at the blend's
  // fixed-point scale.
  // ---------------------------------------------------------------------
  term_t corner_ref [4];
  term_t delta      [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      corner_ref[k] = TERM_W'(s4_c_r[k]) << (2 * FRAC_BITS);
      delta[k] = (s4_blend_r >= corner_ref[k]) ? s4_blend_r - corner_ref[k]
                                               : corner_ref[k] - s4_blend_r;
    end
  end

  logic   s5_vld_r;
  label_t s5_c_r [4];
  term_t  s5_d_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_c_r <= s4_c_r;
    s5_d_r <= delta;
  end

  // ---------------------------------------------------------------------
  // Stage 6: pick the nearest corner. Pairwise strict compares keep the
  // earlier corner on a tie.
  // ---------------------------------------------------------------------
  logic       ab_take_b;
  logic       cd_take_d;
  logic       take_cd;
  term_t      d_ab;
  term_t      d_cd;
  logic [1:0] pick_ab;
  logic [1:0] pick_cd;
  logic [1:0] pick;

  assign ab_take_b = s5_d_r[1] < s5_d_r[0];
  assign cd_take_d = s5_d_r[3] < s5_d_r[2];
  assign d_ab      = ab_take_b ? s5_d_r[1] : s5_d_r[0];
  assign d_cd      = cd_take_d ? s5_d_r[3] : s5_d_r[2];
  assign pick_ab   = ab_take_b ? CORNER_B : CORNER_A;
  assign pick_cd   = cd_take_d ? CORNER_D : CORNER_C;
  assign take_cd   = d_cd < d_ab;
  assign pick      = take_cd ? pick_cd : pick_ab;

  logic       out_vld_r;
  label_t     out_lbl_r;
  logic [1:0] out_pick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_lbl_r  <= s5_c_r[pick];
    out_pick_r <= pick;
  end

  assign out_valid       = out_vld_r;
  assign out_label_out   = out_lbl_r;
  assign out_corner_pick = out_pick_r;

endmodule

[src/lmbu_checker.sv]
module lmbu_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 in_opcode,
  input logic                                 out_valid,
  input logic                                 psel,
  input logic                                 penable,
  input logic                                 pwrite,
  input logic                                 pready,
  input logic [lmbu_pkg::CFG_AW-1:0]          paddr,
  input logic [lmbu_pkg::CFG_DW-1:0]          pwdata,
  input logic [lmbu_pkg::CFG_DW-1:0]          prdata
);
  import lmbu_pkg::*;

  // Every result traces back to an earlier accepted query.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && (in_opcode == OP_QUERY), PIPE_LAT))
    else $error("result word without a matching query");

  // Every query taken with no reset since produces its result on time.
  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(start && !busy && (in_opcode == OP_QUERY), PIPE_LAT) &&
     $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) &&
     $past(rst_n, 4) && $past(rst_n, 5) && $past(rst_n, 6)) |-> out_valid)
    else $error("query lost in the pipeline");

  // Side register reads back what was written.
  a_size_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && (paddr[REG_IDX_LSB] == REG_SIZE)) |=>
    ((paddr[REG_IDX_LSB] != REG_SIZE) ||
     (prdata[SIZE_W-1:0] == $past(pwdata[SIZE_W-1:0]))))
    else $error("low_res_size readback mismatch");

  // Scale register reads back what was written.
  a_scale_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && (paddr[REG_IDX_LSB] == REG_SCALE)) |=>
    ((paddr[REG_IDX_LSB] != REG_SCALE) ||
     (prdata[SCALE_W-1:0] == $past(pwdata[SCALE_W-1:0]))))
    else $error("scale_q16 readback mismatch");

endmodule

bind label_map_bilinear_upsampler_top lmbu_checker u_lmbu_checker (.*);
